@@ design/strip_display_list_assembler_core_assert.svh @@
// Assertion macros for the strip display-list assembler checker.
// Included by the checker file only; no other dependencies.
`ifndef STRIP_DISPLAY_LIST_ASSEMBLER_CORE_ASSERT_SVH
`define STRIP_DISPLAY_LIST_ASSEMBLER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SDLA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define SDLA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/sdla_pkg.sv @@
// Shared types, codes and constants of the strip display-list assembler.
// No dependencies; every design module and interface imports this package.
package sdla_pkg;

    localparam int COUNT_BITS_DEFAULT = 16;
    localparam int IDX_W              = 16;
    localparam int BYTE_W             = 8;
    localparam int CFG_IDX_W          = 3;
    localparam int FIELD_NUM          = 5;
    localparam int VBYTE_W            = 4;   // vertex byte index, up to nine bytes
    localparam int SLOTS              = 3;   // most records one beat can cause
    localparam int FIFO_DEPTH         = 4;
    localparam int FIFO_PTR_W         = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W         = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_VERTEX = 2'd0,
        KIND_TRI    = 2'd1,
        KIND_END    = 2'd2,
        KIND_UNSUP  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_CNT_HI = 2'd1,
        PH_CNT_LO = 2'd2,
        PH_VERTEX = 2'd3
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POS_BYTES   = 3'd0,
        CFG_SEC_BYTES   = 3'd1,
        CFG_UV1_PRESENT = 3'd2,
        CFG_UV2_PRESENT = 3'd3,
        CFG_UV_BYTES    = 3'd4,
        CFG_PAL_PRESENT = 3'd5,
        CFG_STRIP_MASK  = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]        position_index_bytes;
        logic [1:0]        second_index_bytes;
        logic              uv1_present;
        logic              uv2_present;
        logic [1:0]        uv_index_bytes;
        logic              palette_byte_present;
        logic [BYTE_W-1:0] strip_mask;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        position_index_bytes: 2'd2,
        second_index_bytes:   2'd1,
        uv1_present:          1'b0,
        uv2_present:          1'b0,
        uv_index_bytes:       2'd1,
        palette_byte_present: 1'b0,
        strip_mask:           8'd152
    };

    typedef struct packed {
        kind_t             kind;
        logic [IDX_W-1:0]  vertex_number;
        logic [IDX_W-1:0]  position_index;
        logic [IDX_W-1:0]  second_index;
        logic [IDX_W-1:0]  uv_index;
        logic [BYTE_W-1:0] palette_entry;
        logic [IDX_W-1:0]  corner_a;
        logic [IDX_W-1:0]  corner_b;
        logic [IDX_W-1:0]  corner_c;
        logic              last;
    } rec_t;

    // Records produced by one accepted beat, in delivery order
    typedef struct packed {
        logic [1:0]            num;
        rec_t [SLOTS-1:0]      rec;
    } push_t;

    // Index width register: a code of three acts as two bytes
    function automatic logic [1:0] eff_width(input logic [1:0] code);
        eff_width = (code == 2'd3) ? 2'd2 : code;
    endfunction

endpackage

@@ design/sdla_if.sv @@
// Channel interfaces of the strip display-list assembler: byte stream,
// result records and configuration writes. Depend on sdla_pkg.
interface sdla_byte_if import sdla_pkg::*;
    ;
    logic              valid;
    logic              ready;
    logic              list_start;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, list_start, data_byte, input ready);
    modport sink   (input valid, list_start, data_byte, output ready);
endinterface

interface sdla_result_if import sdla_pkg::*;
    ;
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [IDX_W-1:0]  vertex_number;
    logic [IDX_W-1:0]  position_index;
    logic [IDX_W-1:0]  second_index;
    logic [IDX_W-1:0]  uv_index;
    logic [BYTE_W-1:0] palette_entry;
    logic [IDX_W-1:0]  corner_a;
    logic [IDX_W-1:0]  corner_b;
    logic [IDX_W-1:0]  corner_c;
    logic              last;

    modport source (output valid, kind, vertex_number, position_index, second_index,
                    uv_index, palette_entry, corner_a, corner_b, corner_c, last,
                    input ready);
    modport sink   (input valid, kind, vertex_number, position_index, second_index,
                    uv_index, palette_entry, corner_a, corner_b, corner_c, last,
                    output ready);
endinterface

interface sdla_cfg_if import sdla_pkg::*;
    ;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTE_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ design/sdla_cfg_regs.sv @@
// Configuration register file of the strip display-list assembler.
// Depends on sdla_pkg and the sdla_cfg_if interface.
module sdla_cfg_regs import sdla_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    sdla_cfg_if.sink    cfg,
    output cfg_t        cfg_q
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes are always taken
    assign cfg.ready = 1'b1;

    // Decode the register index; unmapped indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_POS_BYTES:   cfg_next.position_index_bytes = cfg.data[1:0];
                CFG_SEC_BYTES:   cfg_next.second_index_bytes   = cfg.data[1:0];
                CFG_UV1_PRESENT: cfg_next.uv1_present          = cfg.data[0];
                CFG_UV2_PRESENT: cfg_next.uv2_present          = cfg.data[0];
                CFG_UV_BYTES:    cfg_next.uv_index_bytes       = cfg.data[1:0];
                CFG_PAL_PRESENT: cfg_next.palette_byte_present = cfg.data[0];
                CFG_STRIP_MASK:  cfg_next.strip_mask           = cfg.data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg_q = cfg_reg;

endmodule

@@ design/sdla_parser.sv @@
// Byte parser and strip assembler: decodes one display-list byte per beat
// and builds up to three records for it. Depends on sdla_pkg, sdla_byte_if.
module sdla_parser import sdla_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg_q,
    sdla_byte_if.sink   byte_stream,
    input  logic        space_ok,
    output logic        push_en,
    output push_t       push
);

    // Parse state
    phase_t                phase_reg,   phase_next;
    logic [VBYTE_W-1:0]    vbyte_reg,   vbyte_next;
    logic [BYTE_W-1:0]     hold_reg,    hold_next;
    logic [COUNT_BITS-1:0] count_reg,   count_next;
    logic [COUNT_BITS-1:0] counter_reg, counter_next;
    logic [COUNT_BITS-1:0] corner0_reg, corner0_next;
    logic [COUNT_BITS-1:0] corner1_reg, corner1_next;
    logic [IDX_W-1:0]      ppos0_reg,   ppos0_next;
    logic [IDX_W-1:0]      ppos1_reg,   ppos1_next;
    logic                  parity_reg,  parity_next;
    logic [IDX_W-1:0]      pos_reg,     pos_next;
    logic [IDX_W-1:0]      sec_reg,     sec_next;
    logic [IDX_W-1:0]      uv_reg,      uv_next;
    logic [BYTE_W-1:0]     pal_reg,     pal_next;

    // Layout and decode
    logic [1:0]            sz  [FIELD_NUM];
    logic [VBYTE_W-1:0]    off [FIELD_NUM];
    logic [VBYTE_W-1:0]    total;
    logic [BYTE_W-1:0]     dec_hold;
    logic [IDX_W-1:0]      dec_pos, dec_sec, dec_uv;
    logic [BYTE_W-1:0]     dec_pal;
    logic [IDX_W-1:0]      dec_val;
    logic [BYTE_W-1:0]     in_byte;
    logic                  accept;

    assign byte_stream.ready = space_ok;
    assign accept            = byte_stream.valid && space_ok;
    assign in_byte           = byte_stream.data_byte;

    // Field sizes and offsets within one vertex
    always_comb
    begin
        sz[0] = cfg_q.palette_byte_present ? 2'd1 : 2'd0;
        sz[1] = eff_width(cfg_q.position_index_bytes);
        sz[2] = eff_width(cfg_q.second_index_bytes);
        sz[3] = cfg_q.uv1_present ? eff_width(cfg_q.uv_index_bytes) : 2'd0;
        sz[4] = cfg_q.uv2_present ? eff_width(cfg_q.uv_index_bytes) : 2'd0;
        off[0] = '0;
        for (int f = 1; f < FIELD_NUM; f++)
        begin
            off[f] = off[f-1] + VBYTE_W'(sz[f-1]);
        end
        total = off[FIELD_NUM-1] + VBYTE_W'(sz[FIELD_NUM-1]);
    end

    // Decode the current vertex byte into its field
    always_comb
    begin
        dec_hold = hold_reg;
        dec_pos  = pos_reg;
        dec_sec  = sec_reg;
        dec_uv   = uv_reg;
        dec_pal  = pal_reg;
        dec_val  = '0;
        for (int f = 0; f < FIELD_NUM; f++)
        begin
            if ((vbyte_reg >= off[f]) && (vbyte_reg < off[f] + VBYTE_W'(sz[f])))
            begin
                if ((sz[f] == 2'd2) && (vbyte_reg == off[f]))
                begin
                    dec_hold = in_byte;
                end
                else
                begin
                    dec_val = (sz[f] == 2'd2) ? {hold_reg, in_byte}
                                              : {{(IDX_W-BYTE_W){1'b0}}, in_byte};
                    case (f)
                        0:       dec_pal = dec_val[BYTE_W-1:0];
                        1:       dec_pos = dec_val;
                        2:       dec_sec = dec_val;
                        3:       dec_uv  = dec_val;
                        default: dec_val = dec_val;   // second texture index is dropped
                    endcase
                end
            end
        end
    end

    // Next state and records of the accepted beat
    always_comb
    begin
        logic [COUNT_BITS-1:0] cnt_rx;
        logic [COUNT_BITS-1:0] counter_inc;
        logic                  vtx_done;
        logic                  tri_ok;
        logic                  list_end;
        logic [1:0]            n;
        rec_t                  vrec;
        rec_t                  trec;
        rec_t                  erec;

        phase_next   = phase_reg;
        vbyte_next   = vbyte_reg;
        hold_next    = hold_reg;
        count_next   = count_reg;
        counter_next = counter_reg;
        corner0_next = corner0_reg;
        corner1_next = corner1_reg;
        ppos0_next   = ppos0_reg;
        ppos1_next   = ppos1_reg;
        parity_next  = parity_reg;
        pos_next     = pos_reg;
        sec_next     = sec_reg;
        uv_next      = uv_reg;
        pal_next     = pal_reg;
        push         = '0;
        push_en      = 1'b0;
        cnt_rx       = COUNT_BITS'({hold_reg, in_byte});
        counter_inc  = counter_reg + COUNT_BITS'(1);
        vtx_done     = ({1'b0, vbyte_reg} + (VBYTE_W+1)'(1)) >= {1'b0, total};
        tri_ok       = 1'b0;
        list_end     = 1'b0;
        n            = '0;
        vrec         = '0;
        trec         = '0;
        erec         = '0;

        if (accept)
        begin
            push_en = 1'b1;
            if (byte_stream.list_start)
            begin
                // Open a new list; any list in progress is dropped
                count_next   = '0;
                counter_next = '0;
                ppos0_next   = '0;
                ppos1_next   = '0;
                corner0_next = '0;
                corner1_next = COUNT_BITS'(1);
                parity_next  = 1'b0;
                pos_next     = '0;
                sec_next     = '0;
                uv_next      = '0;
                pal_next     = '0;
                vbyte_next   = '0;
                if ((in_byte & cfg_q.strip_mask) != '0)
                begin
                    phase_next = PH_CNT_HI;
                end
                else
                begin
                    phase_next      = PH_IDLE;
                    erec.kind       = KIND_UNSUP;
                    erec.last       = 1'b1;
                    push.rec[0]     = erec;
                    push.num        = 2'd1;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_IDLE:
                    begin
                        phase_next = PH_IDLE;
                    end
                    PH_CNT_HI:
                    begin
                        hold_next  = in_byte;
                        phase_next = PH_CNT_LO;
                    end
                    PH_CNT_LO:
                    begin
                        count_next = cnt_rx;
                        if ((cnt_rx == '0) || (total == '0))
                        begin
                            erec.kind          = KIND_END;
                            erec.vertex_number = IDX_W'(cnt_rx);
                            erec.last          = 1'b1;
                            push.rec[0]        = erec;
                            push.num           = 2'd1;
                            phase_next         = PH_IDLE;
                        end
                        else
                        begin
                            pos_next   = '0;
                            sec_next   = '0;
                            uv_next    = '0;
                            pal_next   = '0;
                            vbyte_next = '0;
                            phase_next = PH_VERTEX;
                        end
                    end
                    PH_VERTEX:
                    begin
                        hold_next = dec_hold;
                        pos_next  = dec_pos;
                        sec_next  = dec_sec;
                        uv_next   = dec_uv;
                        pal_next  = dec_pal;
                        if (!vtx_done)
                        begin
                            vbyte_next = vbyte_reg + VBYTE_W'(1);
                        end
                        else
                        begin
                            // Vertex record
                            vrec.kind           = KIND_VERTEX;
                            vrec.vertex_number  = IDX_W'(counter_reg);
                            vrec.position_index = dec_pos;
                            vrec.second_index   = dec_sec;
                            vrec.uv_index       = dec_uv;
                            vrec.palette_entry  = dec_pal;
                            push.rec[0]         = vrec;
                            n                   = 2'd1;

                            // Strip triangle, skipped when degenerate
                            if (counter_reg >= COUNT_BITS'(2))
                            begin
                                tri_ok = (dec_pos != ppos0_reg) && (ppos0_reg != ppos1_reg)
                                      && (dec_pos != ppos1_reg);
                                trec.kind          = KIND_TRI;
                                trec.vertex_number = IDX_W'(counter_reg);
                                trec.corner_a      = parity_reg ? IDX_W'(corner1_reg)
                                                                : IDX_W'(corner0_reg);
                                trec.corner_b      = parity_reg ? IDX_W'(corner0_reg)
                                                                : IDX_W'(corner1_reg);
                                trec.corner_c      = IDX_W'(counter_reg);
                                corner0_next       = corner1_reg;
                                corner1_next       = counter_reg;
                                parity_next        = !parity_reg;
                            end
                            if (tri_ok)
                            begin
                                push.rec[n] = trec;
                                n           = n + 2'd1;
                            end
                            ppos0_next   = ppos1_reg;
                            ppos1_next   = dec_pos;
                            counter_next = counter_inc;

                            // Close the list after its last vertex
                            list_end = (counter_inc == count_reg);
                            if (list_end)
                            begin
                                erec.kind          = KIND_END;
                                erec.vertex_number = IDX_W'(count_reg);
                                erec.last          = 1'b1;
                                push.rec[n]        = erec;
                                n                  = n + 2'd1;
                                phase_next         = PH_IDLE;
                            end
                            else
                            begin
                                pos_next   = '0;
                                sec_next   = '0;
                                uv_next    = '0;
                                pal_next   = '0;
                                vbyte_next = '0;
                                phase_next = PH_VERTEX;
                            end
                            push.num = n;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            vbyte_reg   <= '0;
            hold_reg    <= '0;
            count_reg   <= '0;
            counter_reg <= '0;
            corner0_reg <= '0;
            corner1_reg <= COUNT_BITS'(1);
            ppos0_reg   <= '0;
            ppos1_reg   <= '0;
            parity_reg  <= 1'b0;
            pos_reg     <= '0;
            sec_reg     <= '0;
            uv_reg      <= '0;
            pal_reg     <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            vbyte_reg   <= vbyte_next;
            hold_reg    <= hold_next;
            count_reg   <= count_next;
            counter_reg <= counter_next;
            corner0_reg <= corner0_next;
            corner1_reg <= corner1_next;
            ppos0_reg   <= ppos0_next;
            ppos1_reg   <= ppos1_next;
            parity_reg  <= parity_next;
            pos_reg     <= pos_next;
            sec_reg     <= sec_next;
            uv_reg      <= uv_next;
            pal_reg     <= pal_next;
        end
    end

endmodule

@@ design/sdla_result_fifo.sv @@
// Four-entry record queue between the parser and the result channel:
// takes up to three records per beat, delivers one per cycle while records is ready.
// Depends on sdla_pkg and the sdla_result_if interface.
module sdla_result_fifo import sdla_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_en,
    input  push_t          push,
    output logic           space_ok,
    sdla_result_if.source  records
);

    rec_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg,  count_next;
    logic [1:0]            push_num;
    logic                  pop;
    rec_t                  head;

    assign push_num = push_en ? push.num : 2'd0;
    assign pop      = records.valid && records.ready;
    // Room for a full burst of records
    assign space_ok = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - SLOTS));

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push_num);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        count_next  = count_reg + FIFO_CNT_W'(push_num) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the records of one beat at consecutive entries
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            if (FIFO_CNT_W'(i) < FIFO_CNT_W'(push_num))
            begin
                mem_reg[wr_ptr_reg + FIFO_PTR_W'(i)] <= push.rec[i];
            end
        end
    end

    // Present the oldest record
    assign head                   = mem_reg[rd_ptr_reg];
    assign records.valid          = (count_reg != '0);
    assign records.kind           = head.kind;
    assign records.vertex_number  = head.vertex_number;
    assign records.position_index = head.position_index;
    assign records.second_index   = head.second_index;
    assign records.uv_index       = head.uv_index;
    assign records.palette_entry  = head.palette_entry;
    assign records.corner_a       = head.corner_a;
    assign records.corner_b       = head.corner_b;
    assign records.corner_c       = head.corner_c;
    assign records.last           = head.last;

endmodule

@@ design/strip_display_list_assembler_core.sv @@
// Order: records are queued as their beat is taken and offered on records in that order.
// Throughput: one byte per cycle while each byte yields at most one record and records
// is ready; a byte yielding two or three records sends them one at a time, and
// byte_stream.ready drops while the four-entry record queue holds two or more.
// Reset: rst_n asynchronous, active low; parser idle, registers at defaults, queue empty.
module strip_display_list_assembler_core import sdla_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    sdla_cfg_if.sink      cfg,
    sdla_byte_if.sink     byte_stream,
    sdla_result_if.source records
);

    cfg_t  cfg_q;
    logic  space_ok;
    logic  push_en;
    push_t push;

    sdla_cfg_regs u_cfg_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .cfg_q  (cfg_q)
    );

    sdla_parser #(
        .COUNT_BITS (COUNT_BITS)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_q       (cfg_q),
        .byte_stream (byte_stream),
        .space_ok    (space_ok),
        .push_en     (push_en),
        .push        (push)
    );

    sdla_result_fifo u_result_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_en  (push_en),
        .push     (push),
        .space_ok (space_ok),
        .records  (records)
    );

endmodule

@@ design/sdla_checker.sv @@
// Port-level checks of the strip display-list assembler, bound to the top level.
// Depends on sdla_pkg and strip_display_list_assembler_core_assert.svh.
`include "strip_display_list_assembler_core_assert.svh"

module sdla_checker import sdla_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             rec_valid,
    input logic             rec_ready,
    input logic [1:0]       rec_kind,
    input logic [IDX_W-1:0] rec_vertex_number,
    input logic [IDX_W-1:0] rec_corner_c,
    input logic             rec_last
);

    // A stalled record stays offered
    `SDLA_ASSERT_NEXT(a_rec_hold, clk, rst_n, rec_valid && !rec_ready, rec_valid, "record dropped while stalled")

    // Only end and unsupported records close a list
    `SDLA_ASSERT_NOW(a_last_kind, clk, rst_n, rec_valid, rec_last == ((rec_kind == KIND_END) || (rec_kind == KIND_UNSUP)), "last flag does not match record kind")

    // A triangle always ends on the newest vertex
    `SDLA_ASSERT_NOW(a_tri_newest, clk, rst_n, rec_valid && (rec_kind == KIND_TRI), rec_corner_c == rec_vertex_number, "triangle third corner is not the newest vertex")

    // An unsupported record carries no vertex number
    `SDLA_ASSERT_NOW(a_unsup_zero, clk, rst_n, rec_valid && (rec_kind == KIND_UNSUP), rec_vertex_number == '0, "unsupported record with nonzero vertex number")

endmodule

bind strip_display_list_assembler_core sdla_checker u_sdla_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .rec_valid         (records.valid),
    .rec_ready         (records.ready),
    .rec_kind          (records.kind),
    .rec_vertex_number (records.vertex_number),
    .rec_corner_c      (records.corner_c),
    .rec_last          (records.last)
);

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking bench for strip_display_list_assembler_core: a directed table of stream
// beats, then random display lists under several register settings, all scored by a predictor.
// Depends on sdla_pkg, the sdla channel interfaces and the core RTL.
module tb_top;
    import sdla_pkg::*;

    localparam int SETTLE      = 4;
    localparam int STALL_LIMIT = 500;
    localparam int REPORT_MAX  = 10;

    typedef enum bit {ROW_BEAT, ROW_REG} row_op_t;

    typedef struct {
        row_op_t    op;
        logic       ls;
        logic [7:0] val;
        cfg_idx_t   reg_idx;
        bit         typed;
        rec_t       want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    sdla_cfg_if    cfg_ch();
    sdla_byte_if   stream_ch();
    sdla_result_if rec_ch();

    strip_display_list_assembler_core uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_ch),
        .byte_stream (stream_ch),
        .records     (rec_ch)
    );

    // Predictor copy of registers and parser state
    cfg_t        shadow;
    phase_t      track_phase;
    int unsigned vbyte;
    logic [7:0]  held_byte;
    logic [7:0]  cur_pal;
    logic [15:0] cur_pos;
    logic [15:0] cur_sec;
    logic [15:0] cur_uv;
    logic [15:0] list_len;
    logic [15:0] verts_done;
    logic [15:0] pos_hist [2];
    logic [15:0] corner_hist [2];
    logic        flip;

    rec_t        expected_records [$];
    stim_row_t   plan [$];
    bit          steady;
    int unsigned mismatches;
    int unsigned records_checked;
    int unsigned beats_fed;
    int unsigned items_fed;
    int unsigned directed_beats;
    int unsigned settings_applied;
    int unsigned triangles_made;
    int unsigned triangles_dropped;
    int unsigned stall_cycles;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic rec_t blank_rec(input kind_t kd, input logic [15:0] vn, input logic lst);
        rec_t r;
        r               = '0;
        r.kind          = kd;
        r.vertex_number = vn;
        r.last          = lst;
        return r;
    endfunction

    // Bytes taken by one vertex field: palette, position, second, uv1, uv2
    function automatic int unsigned field_size(input int unsigned f);
        logic [1:0] code;
        case (f)
            0: return int'(shadow.palette_byte_present);
            1: code = shadow.position_index_bytes;
            2: code = shadow.second_index_bytes;
            default:
                code = ((f == 3) ? shadow.uv1_present : shadow.uv2_present) ?
                       shadow.uv_index_bytes : 2'd0;
        endcase
        return (code == 2'd3) ? 2 : int'(code);
    endfunction

    function automatic int unsigned vertex_bytes();
        int unsigned sum;
        sum = 0;
        for (int f = 0; f < 5; f++)
            sum += field_size(f);
        return sum;
    endfunction

    function automatic void clear_fields();
        cur_pos = '0;
        cur_sec = '0;
        cur_uv  = '0;
        cur_pal = '0;
    endfunction

    // Advance the parser by one stream beat and return the records it causes
    function automatic int unsigned predict_beat(input logic ls, input logic [7:0] val,
                                                 output rec_t res [3]);
        int unsigned total;
        int unsigned off;
        int unsigned n;
        logic [15:0] field_val;
        bit          placed;
        rec_t        r;
        n      = 0;
        off    = 0;
        placed = 1'b0;
        for (int i = 0; i < 3; i++)
            res[i] = '0;
        total = vertex_bytes();

        // Draw-type byte: restart the list, or report an unsupported draw type
        if (ls)
        begin
            list_len       = '0;
            verts_done     = '0;
            pos_hist[0]    = '0;
            pos_hist[1]    = '0;
            corner_hist[0] = 16'd0;
            corner_hist[1] = 16'd1;
            flip           = 1'b0;
            clear_fields();
            if ((val & shadow.strip_mask) != 8'd0)
            begin
                track_phase = PH_CNT_HI;
                return 0;
            end
            track_phase = PH_IDLE;
            res[0] = blank_rec(KIND_UNSUP, 16'd0, 1'b1);
            return 1;
        end
        if (track_phase == PH_IDLE)
            return 0;
        if (track_phase == PH_CNT_HI)
        begin
            held_byte   = val;
            track_phase = PH_CNT_LO;
            return 0;
        end
        if (track_phase == PH_CNT_LO)
        begin
            list_len = {held_byte, val};
            if (list_len == 16'd0 || total == 0)
            begin
                res[0]      = blank_rec(KIND_END, list_len, 1'b1);
                track_phase = PH_IDLE;
                return 1;
            end
            clear_fields();
            vbyte       = 0;
            track_phase = PH_VERTEX;
            return 0;
        end

        // Vertex byte: hold a high byte or store a finished field
        if (vbyte < total)
        begin
            for (int unsigned f = 0; f < 5; f++)
            begin
                if (!placed && vbyte < off + field_size(f))
                begin
                    placed = 1'b1;
                    if (field_size(f) == 2 && vbyte == off)
                        held_byte = val;
                    else
                    begin
                        field_val = (field_size(f) == 2) ? {held_byte, val} : {8'h00, val};
                        case (f)
                            0: cur_pal = field_val[7:0];
                            1: cur_pos = field_val;
                            2: cur_sec = field_val;
                            3: cur_uv  = field_val;
                            default: ;
                        endcase
                    end
                end
                off += field_size(f);
            end
        end
        if (vbyte + 1 < total)
        begin
            vbyte++;
            return 0;
        end

        // Vertex complete
        r                = blank_rec(KIND_VERTEX, verts_done, 1'b0);
        r.position_index = cur_pos;
        r.second_index   = cur_sec;
        r.uv_index       = cur_uv;
        r.palette_entry  = cur_pal;
        res[n++]         = r;

        // Strip triangle, dropped when two positions coincide
        if (verts_done >= 16'd2)
        begin
            if (cur_pos != pos_hist[0] && pos_hist[0] != pos_hist[1] && cur_pos != pos_hist[1])
            begin
                r          = blank_rec(KIND_TRI, verts_done, 1'b0);
                r.corner_a = flip ? corner_hist[1] : corner_hist[0];
                r.corner_b = flip ? corner_hist[0] : corner_hist[1];
                r.corner_c = verts_done;
                res[n++]   = r;
                triangles_made++;
            end
            else
                triangles_dropped++;
            corner_hist[0] = corner_hist[1];
            corner_hist[1] = verts_done;
            flip           = ~flip;
        end
        pos_hist[0] = pos_hist[1];
        pos_hist[1] = cur_pos;
        verts_done  = verts_done + 16'd1;

        if (verts_done == list_len)
        begin
            res[n++]    = blank_rec(KIND_END, list_len, 1'b1);
            track_phase = PH_IDLE;
        end
        else
        begin
            clear_fields();
            vbyte = 0;
        end
        return n;
    endfunction

    function automatic void add_beat(input logic ls, input logic [7:0] val);
        stim_row_t row;
        row = '{ROW_BEAT, ls, val, CFG_POS_BYTES, 1'b0, '0};
        plan.insert(plan.size(), row);
    endfunction

    function automatic void add_typed(input logic ls, input logic [7:0] val, input rec_t want);
        stim_row_t row;
        row = '{ROW_BEAT, ls, val, CFG_POS_BYTES, 1'b1, want};
        plan.insert(plan.size(), row);
    endfunction

    function automatic void add_reg(input cfg_idx_t idx, input logic [7:0] val);
        stim_row_t row;
        row = '{ROW_REG, 1'b0, val, idx, 1'b0, '0};
        plan.insert(plan.size(), row);
    endfunction

    // Drive one stream beat, wait for it to be taken, then log what it should cause
    task automatic send_beat(input logic ls, input logic [7:0] val,
                             input bit typed = 1'b0, input rec_t want = '0);
        rec_t        res [3];
        int unsigned n;
        if (!steady)
            while ($urandom_range(0, 99) < 8)
            begin
                stream_ch.valid <= 1'b0;
                @(posedge clk);
            end
        stream_ch.valid      <= 1'b1;
        stream_ch.list_start <= ls;
        stream_ch.data_byte  <= val;
        do
            @(posedge clk);
        while (!stream_ch.ready);
        beats_fed++;
        if (ls || track_phase != PH_IDLE)
            items_fed++;
        n = predict_beat(ls, val, res);
        if (typed)
            expected_records.insert(expected_records.size(), want);
        else
            for (int i = 0; i < n; i++)
                expected_records.insert(expected_records.size(), res[i]);
    endtask

    // Hold the stream until every pending record has come out, then let the core settle
    task automatic drain_records();
        stream_ch.valid <= 1'b0;
        while (expected_records.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [7:0] val);
        drain_records();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_POS_BYTES:   shadow.position_index_bytes = val[1:0];
            CFG_SEC_BYTES:   shadow.second_index_bytes   = val[1:0];
            CFG_UV1_PRESENT: shadow.uv1_present          = val[0];
            CFG_UV2_PRESENT: shadow.uv2_present          = val[0];
            CFG_UV_BYTES:    shadow.uv_index_bytes       = val[1:0];
            CFG_PAL_PRESENT: shadow.palette_byte_present = val[0];
            CFG_STRIP_MASK:  shadow.strip_mask           = val;
            default: ;
        endcase
    endtask

    task automatic apply_setting(input logic [7:0] pos_w, input logic [7:0] sec_w,
                                 input logic [7:0] uv1, input logic [7:0] uv2,
                                 input logic [7:0] uv_w, input logic [7:0] pal,
                                 input logic [7:0] mask);
        settings_applied++;
        write_reg(CFG_POS_BYTES, pos_w);
        write_reg(CFG_SEC_BYTES, sec_w);
        write_reg(CFG_UV1_PRESENT, uv1);
        write_reg(CFG_UV2_PRESENT, uv2);
        write_reg(CFG_UV_BYTES, uv_w);
        write_reg(CFG_PAL_PRESENT, pal);
        write_reg(CFG_STRIP_MASK, mask);
    endtask

    // Mostly well-formed lists with random content, plus noise and cut-short lists
    task automatic feed_random_lists(input int unsigned budget);
        int unsigned goal;
        int unsigned roll;
        int unsigned nbytes;
        logic [7:0]  draw;
        logic [15:0] cnt;
        goal = items_fed + budget;
        while (items_fed < goal)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 10)
                send_beat($urandom_range(0, 3) == 0, 8'($urandom_range(0, 255)));
            else if (roll < 13)
                drain_records();
            else
            begin
                draw = 8'($urandom_range(0, 255));
                if (shadow.strip_mask != 8'd0 && roll < 92)
                    while ((draw & shadow.strip_mask) == 8'd0)
                        draw = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 19) == 0)
                    cnt = 16'($urandom_range(0, 65535));
                else
                    cnt = 16'($urandom_range(0, 6));
                send_beat(1'b1, draw);
                send_beat(1'b0, cnt[15:8]);
                send_beat(1'b0, cnt[7:0]);
                nbytes = ((cnt > 16'd8) ? 8 : int'(cnt)) * vertex_bytes();
                if ($urandom_range(0, 9) == 0)
                    nbytes = $urandom_range(0, nbytes);
                for (int unsigned i = 0; i < nbytes; i++)
                    send_beat(1'b0, $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) :
                                                          8'($urandom_range(0, 2)));
            end
        end
    endtask

    task automatic compare_field(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("Record %0d: %s expected 0x%0h, got 0x%0h",
                         records_checked, what, want, got);
        end
    endtask

    // Score every record beat against the oldest expectation
    always @(posedge clk)
    begin : check_records
        rec_t want;
        if (rst_n && rec_ch.valid && rec_ch.ready)
        begin
            records_checked++;
            if (expected_records.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("Record %0d: none expected, got kind %0d vertex %0d",
                             records_checked, rec_ch.kind, rec_ch.vertex_number);
            end
            else
            begin
                want = expected_records.pop_front();
                compare_field("kind", 16'(want.kind), 16'(rec_ch.kind));
                compare_field("vertex_number", want.vertex_number, rec_ch.vertex_number);
                compare_field("position_index", want.position_index, rec_ch.position_index);
                compare_field("second_index", want.second_index, rec_ch.second_index);
                compare_field("uv_index", want.uv_index, rec_ch.uv_index);
                compare_field("palette_entry", 16'(want.palette_entry),
                              16'(rec_ch.palette_entry));
                compare_field("corner_a", want.corner_a, rec_ch.corner_a);
                compare_field("corner_b", want.corner_b, rec_ch.corner_b);
                compare_field("corner_c", want.corner_c, rec_ch.corner_c);
                compare_field("last", 16'(want.last), 16'(rec_ch.last));
            end
        end
    end

    // Record sink: stall now and then unless in a steady stretch
    always @(posedge clk)
        rec_ch.ready <= steady || ($urandom_range(0, 99) >= 8);

    // Watchdog on cycles with no beat taken on any channel
    always @(posedge clk)
    begin
        if ((stream_ch.valid && stream_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
            (rec_ch.valid && rec_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        rst_n                = 1'b0;
        steady               = 1'b0;
        stream_ch.valid      = 1'b0;
        stream_ch.list_start = 1'b0;
        stream_ch.data_byte  = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = '0;
        cfg_ch.data          = '0;
        rec_ch.ready         = 1'b0;

        // Register and parser values after reset
        shadow.position_index_bytes = 2'd2;
        shadow.second_index_bytes   = 2'd1;
        shadow.uv1_present          = 1'b0;
        shadow.uv2_present          = 1'b0;
        shadow.uv_index_bytes       = 2'd1;
        shadow.palette_byte_present = 1'b0;
        shadow.strip_mask           = 8'd152;
        track_phase    = PH_IDLE;
        vbyte          = 0;
        held_byte      = '0;
        list_len       = '0;
        verts_done     = '0;
        pos_hist[0]    = '0;
        pos_hist[1]    = '0;
        corner_hist[0] = 16'd0;
        corner_hist[1] = 16'd1;
        flip           = 1'b0;
        clear_fields();

        // Unsupported draw type, then a stray byte while idle
        add_typed(1'b1, 8'h00, blank_rec(KIND_UNSUP, 16'd0, 1'b1));
        add_beat(1'b0, 8'hFF);
        // Empty list
        add_beat(1'b1, 8'h98);
        add_beat(1'b0, 8'h00);
        add_typed(1'b0, 8'h00, blank_rec(KIND_END, 16'd0, 1'b1));
        // Three vertices at the byte extremes: one triangle and the end record
        add_beat(1'b1, 8'h80);
        add_beat(1'b0, 8'h00);
        add_beat(1'b0, 8'h03);
        add_beat(1'b0, 8'hFF);
        add_beat(1'b0, 8'hFF);
        add_beat(1'b0, 8'hFF);
        add_beat(1'b0, 8'h00);
        add_beat(1'b0, 8'h00);
        add_beat(1'b0, 8'h00);
        add_beat(1'b0, 8'h12);
        add_beat(1'b0, 8'h34);
        add_beat(1'b0, 8'h56);
        // A new list cuts the previous one short
        add_beat(1'b1, 8'h10);
        add_beat(1'b0, 8'h00);
        add_beat(1'b0, 8'h05);
        add_beat(1'b0, 8'h01);
        add_beat(1'b1, 8'h08);
        add_beat(1'b0, 8'h00);
        add_beat(1'b0, 8'h02);
        add_beat(1'b0, 8'hAB);
        add_beat(1'b0, 8'hCD);
        // Shrink the layout mid-vertex; the next byte closes the vertex undecoded
        add_reg(CFG_POS_BYTES, 8'd0);
        add_reg(CFG_SEC_BYTES, 8'd0);
        add_beat(1'b0, 8'h77);
        // Zero-byte vertices: the end record follows the count
        add_beat(1'b1, 8'h08);
        add_beat(1'b0, 8'h00);
        add_typed(1'b0, 8'h04, blank_rec(KIND_END, 16'd4, 1'b1));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        foreach (plan[i])
        begin
            if (plan[i].op == ROW_REG)
                write_reg(plan[i].reg_idx, plan[i].val);
            else
                send_beat(plan[i].ls, plan[i].val, plan[i].typed, plan[i].want);
        end
        directed_beats = beats_fed;

        // Widest layout, every nonzero draw type a strip
        apply_setting(8'd2, 8'd2, 8'd1, 8'd1, 8'd2, 8'd1, 8'd255);
        feed_random_lists(40);
        // Width code three on every index
        apply_setting(8'd3, 8'd3, 8'($urandom_range(0, 1)), 8'($urandom_range(0, 1)), 8'd3,
                      8'($urandom_range(0, 1)), 8'($urandom_range(1, 255)));
        feed_random_lists(40);
        // Everything zero: every draw type unsupported
        apply_setting(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        feed_random_lists(12);
        // Empty vertex layout with strips allowed
        write_reg(CFG_STRIP_MASK, 8'h98);
        feed_random_lists(12);
        // Random layout with no random stream gaps or record-sink stalls
        apply_setting(8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                      8'($urandom_range(0, 1)), 8'($urandom_range(0, 1)),
                      8'($urandom_range(0, 3)), 8'($urandom_range(0, 1)),
                      8'($urandom_range(0, 255)));
        steady = 1'b1;
        feed_random_lists(60);
        steady = 1'b0;
        repeat (3)
        begin
            apply_setting(8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                          8'($urandom_range(0, 1)), 8'($urandom_range(0, 1)),
                          8'($urandom_range(0, 3)), 8'($urandom_range(0, 1)),
                          8'($urandom_range(0, 255)));
            feed_random_lists(40);
        end

        drain_records();
        repeat (8) @(posedge clk);

        $display("Run: %0d stream beats (%0d directed) over %0d register settings, %0d records",
                 beats_fed, directed_beats, settings_applied + 1, records_checked);
        $display("Run: %0d triangles assembled, %0d degenerate ones dropped, %0d mismatches",
                 triangles_made, triangles_dropped, mismatches);
        if (mismatches == 0 && expected_records.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
